// ===== rtl/mf2d_pkg.sv =====
// Shared types and constants for the 2-D median filter.
// Used by median_filter_2d; depends on nothing else.
package mf2d_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_WINDOW  = 7;
    localparam int MAX_HEIGHT  = 4096;
    localparam int STORE_ROWS  = MAX_WINDOW + 1;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int SROW_W      = $clog2(STORE_ROWS);
    localparam int ADDR_W      = SROW_W + COL_W;
    localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
    localparam int WIN_LEN     = MAX_WINDOW * MAX_WINDOW;
    localparam int WIN_CNT_W   = $clog2(WIN_LEN + 1);
    localparam int HALF_W      = $clog2(MAX_WINDOW / 2 + 1);
    localparam int SIDE_W      = $clog2(MAX_WINDOW + 1);
    localparam int PIX_W       = 8;
    localparam int BIT_W       = $clog2(PIX_W);
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int WIN_REG_W    = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

    // commands
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] median_out;
        logic             frame_last;
    } out_item_t;

endpackage

// ===== rtl/median_filter_2d.sv =====
// Streaming 2-D median filter with replicated borders, top level.
// Depends on mf2d_pkg.
//
// Usage: pixels arrive on the in channel (valid/ready) in raster order,
// command 0 pushing pixel_in and command 1 draining one pending output.
// Each request gives at most one result on the out channel (valid/ready):
// the median of the window around the next output position, with
// frame_last set on the last pixel of the frame. Configuration is written
// through cfg_wr_en/cfg_index/cfg_data while idle and restarts the frame.
// Timing: a request that gives no result only passes through the emission check.
// For one that gives a result, the window is read from the line store one pixel
// a cycle into a 49-deep shift chain, then the median is found one bit a
// pass, each pass rotating the whole chain once. The single read port of the
// line store and the chain rotation set how long a result takes.
// The result sits in an output register, so a new request is accepted while
// the receiver stalls; the block waits only when a second result is ready
// before the first was taken. Reset sets width 640, height 480, window 3
// and empties the frame; the line store needs no clearing.
module median_filter_2d (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mf2d_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output mf2d_pkg::out_item_t              out_data,
    input  logic                             cfg_wr_en,
    input  logic [mf2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mf2d_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mf2d_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GATHER,
        ST_SELECT,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [WIDTH_REG_W-1:0]  width_reg, width_next;
    logic [HEIGHT_REG_W-1:0] height_reg, height_next;
    logic [WIN_REG_W-1:0]    win_reg, win_next;
    logic [ROW_W-1:0]        in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COL_W-1:0]        in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic                    frame_full_reg, frame_full_next;
    logic                    out_active_reg, out_active_next;
    logic [SIDE_W-1:0]       wi_reg, wi_next, wj_reg, wj_next;
    logic [WIN_CNT_W-1:0]    step_reg, step_next;
    logic [WIN_CNT_W-1:0]    cnt_reg, cnt_next, rank_reg, rank_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic [PIX_W-1:0]        res_reg, res_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;

    // line store and window chain
    logic [PIX_W-1:0]        store_mem [STORE_DEPTH];
    logic [PIX_W-1:0]        rd_data_reg;
    logic [PIX_W-1:0]        chain_reg [WIN_LEN];
    logic [WIN_LEN-1:0]      chain_v_reg;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr, rd_addr;
    logic                    chain_shift;
    logic [PIX_W-1:0]        chain_in;
    logic                    chain_v_in;

    // effective configuration
    logic [COL_W-1:0]        wm1;
    logic [ROW_W-1:0]        hm1;
    logic [HALF_W-1:0]       half;
    logic [SIDE_W-1:0]       side;
    logic [WIN_CNT_W-1:0]    win_n;

    always_comb
    begin
        if (width_reg == '0)
            wm1 = '0;
        else if (width_reg > WIDTH_REG_W'(MAX_WIDTH))
            wm1 = COL_W'(MAX_WIDTH - 1);
        else
            wm1 = COL_W'(width_reg - 1'b1);
        if (height_reg == '0)
            hm1 = '0;
        else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
            hm1 = ROW_W'(MAX_HEIGHT - 1);
        else
            hm1 = ROW_W'(height_reg - 1'b1);
        if (win_reg == '0)
            half = '0;
        else
            half = HALF_W'((win_reg - 1'b1) >> 1);
        side  = SIDE_W'({half, 1'b1});
        win_n = WIN_CNT_W'(side * side);
    end

    // readiness of the next output
    logic [ROW_W:0]  nr_sum;
    logic [COL_W:0]  nc_sum;
    logic [ROW_W-1:0] nr;
    logic [COL_W-1:0] nc;
    logic            can_emit;

    always_comb
    begin
        nr_sum = {1'b0, out_row_reg} + (ROW_W+1)'(half);
        nc_sum = {1'b0, out_col_reg} + (COL_W+1)'(half);
        nr = (nr_sum > {1'b0, hm1}) ? hm1 : nr_sum[ROW_W-1:0];
        nc = (nc_sum > {1'b0, wm1}) ? wm1 : nc_sum[COL_W-1:0];
        can_emit = out_active_reg &&
                   (frame_full_reg || (nr < in_row_reg) ||
                    ((nr == in_row_reg) && (nc < in_col_reg)));
    end

    // clamped window position for the read address
    logic [ROW_W:0]   rt;
    logic [COL_W:0]   ct;
    logic [ROW_W-1:0] rr;
    logic [COL_W-1:0] cc;

    always_comb
    begin
        rt = {1'b0, out_row_reg} + (ROW_W+1)'(wi_reg);
        ct = {1'b0, out_col_reg} + (COL_W+1)'(wj_reg);
        if (rt < (ROW_W+1)'(half))
            rr = '0;
        else if ((rt - (ROW_W+1)'(half)) > {1'b0, hm1})
            rr = hm1;
        else
            rr = ROW_W'(rt - (ROW_W+1)'(half));
        if (ct < (COL_W+1)'(half))
            cc = '0;
        else if ((ct - (COL_W+1)'(half)) > {1'b0, wm1})
            cc = wm1;
        else
            cc = COL_W'(ct - (COL_W+1)'(half));
        rd_addr = {rr[SROW_W-1:0], cc};
    end

    // bit-serial selection terms
    logic [PIX_W-1:0]     hi_mask;
    logic [PIX_W-1:0]     tap;
    logic                 cand;
    logic [WIN_CNT_W-1:0] cnt_full;

    always_comb
    begin
        hi_mask  = PIX_W'(16'hFF00 >> (3'd7 - bit_reg));
        tap      = chain_reg[WIN_LEN-1];
        cand     = chain_v_reg[WIN_LEN-1] && (((tap ^ res_reg) & hi_mask) == '0) &&
                   !tap[bit_reg];
        cnt_full = cnt_reg + WIN_CNT_W'(cand);
    end

    // next-state logic
    logic new_frame;

    always_comb
    begin
        state_next      = state_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        win_next        = win_reg;
        in_row_next     = in_row_reg;
        in_col_next     = in_col_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        frame_full_next = frame_full_reg;
        out_active_next = out_active_reg;
        wi_next         = wi_reg;
        wj_next         = wj_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        rank_next       = rank_reg;
        bit_next        = bit_reg;
        res_next        = res_reg;
        rd_vld_next     = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        chain_shift     = 1'b0;
        chain_in        = rd_data_reg;
        chain_v_in      = rd_vld_reg;
        new_frame       = frame_full_reg || ((in_row_reg == '0) && (in_col_reg == '0));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    unique case (cfg_index)
                        REG_WIDTH:  width_next  = cfg_data[WIDTH_REG_W-1:0];
                        REG_HEIGHT: height_next = cfg_data[HEIGHT_REG_W-1:0];
                        REG_WINDOW: win_next    = cfg_data[WIN_REG_W-1:0];
                        default: ;
                    endcase
                    if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                        cfg_index == REG_WINDOW)
                    begin
                        in_row_next     = '0;
                        in_col_next     = '0;
                        out_row_next    = '0;
                        out_col_next    = '0;
                        frame_full_next = 1'b0;
                        out_active_next = 1'b0;
                    end
                end
                else if (in_valid)
                begin
                    state_next = ST_CHECK;
                    if (in_data.command == CMD_PUSH)
                    begin
                        logic [ROW_W-1:0] row_w;
                        logic [COL_W-1:0] col_w;
                        row_w = new_frame ? '0 : in_row_reg;
                        col_w = new_frame ? '0 : in_col_reg;
                        if (new_frame)
                        begin
                            out_row_next    = '0;
                            out_col_next    = '0;
                            frame_full_next = 1'b0;
                            out_active_next = 1'b1;
                        end
                        wr_en   = 1'b1;
                        wr_addr = {row_w[SROW_W-1:0], col_w};
                        if (col_w == wm1)
                        begin
                            in_col_next = '0;
                            if (row_w == hm1)
                            begin
                                in_row_next     = '0;
                                frame_full_next = 1'b1;
                            end
                            else
                                in_row_next = row_w + 1'b1;
                        end
                        else
                        begin
                            in_row_next = row_w;
                            in_col_next = col_w + 1'b1;
                        end
                    end
                end
            end

            ST_CHECK:
            begin
                if (can_emit)
                begin
                    state_next = ST_GATHER;
                    wi_next    = '0;
                    wj_next    = '0;
                    step_next  = '0;
                end
                else
                    state_next = ST_IDLE;
            end

            // read one window pixel a cycle; the registered read data enters the chain in the next cycle
            ST_GATHER:
            begin
                rd_vld_next = (step_reg < win_n);
                if (step_reg < win_n)
                begin
                    if (wj_reg == side - 1'b1)
                    begin
                        wj_next = '0;
                        wi_next = wi_reg + 1'b1;
                    end
                    else
                        wj_next = wj_reg + 1'b1;
                end
                chain_shift = (step_reg != '0);
                if (step_reg == WIN_CNT_W'(WIN_LEN))
                begin
                    state_next = ST_SELECT;
                    step_next  = '0;
                    cnt_next   = '0;
                    rank_next  = win_n >> 1;
                    bit_next   = BIT_W'(PIX_W - 1);
                    res_next   = '0;
                end
                else
                    step_next = step_reg + 1'b1;
            end

            // one bit of the median per full rotation of the chain
            ST_SELECT:
            begin
                chain_shift = 1'b1;
                chain_in    = tap;
                chain_v_in  = chain_v_reg[WIN_LEN-1];
                if (step_reg == WIN_CNT_W'(WIN_LEN - 1))
                begin
                    step_next = '0;
                    cnt_next  = '0;
                    if (rank_reg >= cnt_full)
                    begin
                        res_next[bit_reg] = 1'b1;
                        rank_next         = rank_reg - cnt_full;
                    end
                    if (bit_reg == '0)
                        state_next = ST_DONE;
                    else
                        bit_next = bit_reg - 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                    cnt_next  = cnt_full;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next               = ST_IDLE;
                    out_valid_next           = 1'b1;
                    out_data_next.median_out = res_reg;
                    out_data_next.frame_last = (out_row_reg == hm1) && (out_col_reg == wm1);
                    if (out_col_reg == wm1)
                    begin
                        out_col_next = '0;
                        if (out_row_reg == hm1)
                        begin
                            out_row_next    = '0;
                            out_active_next = 1'b0;
                        end
                        else
                            out_row_next = out_row_reg + 1'b1;
                    end
                    else
                        out_col_next = out_col_reg + 1'b1;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_reg      <= WIDTH_REG_W'(640);
            height_reg     <= HEIGHT_REG_W'(480);
            win_reg        <= WIN_REG_W'(3);
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            frame_full_reg <= 1'b0;
            out_active_reg <= 1'b0;
            wi_reg         <= '0;
            wj_reg         <= '0;
            step_reg       <= '0;
            cnt_reg        <= '0;
            rank_reg       <= '0;
            bit_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            win_reg        <= win_next;
            in_row_reg     <= in_row_next;
            in_col_reg     <= in_col_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            frame_full_reg <= frame_full_next;
            out_active_reg <= out_active_next;
            wi_reg         <= wi_next;
            wj_reg         <= wj_next;
            step_reg       <= step_next;
            cnt_reg        <= cnt_next;
            rank_reg       <= rank_next;
            bit_reg        <= bit_next;
            rd_vld_reg     <= rd_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // line store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= in_data.pixel_in;
        rd_data_reg <= store_mem[rd_addr];
    end

    // window chain: fills while gathering, rotates while selecting
    always_ff @(posedge clk)
    begin
        if (chain_shift)
        begin
            chain_reg[0]   <= chain_in;
            chain_v_reg[0] <= chain_v_in;
            for (int i = 1; i < WIN_LEN; i++)
            begin
                chain_reg[i]   <= chain_reg[i-1];
                chain_v_reg[i] <= chain_v_reg[i-1];
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // an accepted request always leaves idle for the emission check
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CHECK))
        else $error("request accepted but controller stayed idle");

    // output position stays inside the frame while outputs are pending
    a_out_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_active_reg |-> ((out_row_reg <= hm1) && (out_col_reg <= wm1)))
        else $error("output position outside the frame");

    // a finished median waits while the held result is not taken
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=>
        (state_reg == ST_DONE && $stable(out_data_reg)))
        else $error("result overwritten before it was taken");
`endif

endmodule

// ===== tb/sv/median_checker.sv =====
`timescale 1ns / 100ps
// Checker for median_filter_2d: predicts the median stream and compares results.
// Depends on mf2d_pkg; instantiated by tb_top beside the block.
module median_checker
    import mf2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output bit                    frame_open
);

    // predictor state
    logic [PIX_W-1:0]        pix_store [STORE_DEPTH];
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [WIN_REG_W-1:0]    win_reg;
    int unsigned             in_r, in_c, out_r, out_c;
    bit                      frame_full;
    out_item_t               medians_due [$];

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic int unsigned eff_half();
        int unsigned s;
        s = (win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg;
        if (s == 0) s = 1;
        if (s % 2 == 0) s = s - 1;
        return s / 2;
    endfunction

    // replicate border: clamp base+off-half into [0, lim-1]
    function automatic int unsigned clamp_pos(int unsigned base, int unsigned off,
                                              int unsigned half, int unsigned lim);
        if (base + off < half) return 0;
        if (base + off - half > lim - 1) return lim - 1;
        return base + off - half;
    endfunction

    function automatic logic [PIX_W-1:0] median_at_out_pos(int unsigned w, int unsigned h,
                                                           int unsigned half);
        logic [PIX_W-1:0] vals [$];
        int unsigned      r, c;
        for (int unsigned i = 0; i < 2 * half + 1; i++) begin
            r = clamp_pos(out_r, i, half, h);
            for (int unsigned j = 0; j < 2 * half + 1; j++) begin
                c = clamp_pos(out_c, j, half, w);
                vals.push_back(pix_store[(r % STORE_ROWS) * MAX_WIDTH + c]);
            end
        end
        vals.sort();
        return vals[vals.size() / 2];
    endfunction

    // one request: store the pixel if pushed, then give the next ready median if any
    task automatic predict_request(in_item_t req);
        int unsigned w, h, half, nr, nc;
        out_item_t   res;
        w = eff_width();
        h = eff_height();
        half = eff_half();
        if (req.command == CMD_PUSH) begin
            // new frame: results already given still come out
            if (frame_full || (in_r == 0 && in_c == 0)) begin
                in_r = 0; in_c = 0; out_r = 0; out_c = 0;
                frame_full = 0;
                frame_open = 1;
            end
            pix_store[(in_r % STORE_ROWS) * MAX_WIDTH + in_c] = req.pixel_in;
            in_c++;
            if (in_c >= w) begin
                in_c = 0;
                in_r++;
                if (in_r >= h) begin
                    in_r = 0;
                    frame_full = 1;
                end
            end
        end
        if (!frame_open) return;
        if (!frame_full) begin
            nr = (out_r + half > h - 1) ? h - 1 : out_r + half;
            nc = (out_c + half > w - 1) ? w - 1 : out_c + half;
            if (nr * w + nc >= in_r * w + in_c) return;
        end
        res.median_out = median_at_out_pos(w, h, half);
        res.frame_last = (out_r == h - 1 && out_c == w - 1);
        medians_due.push_back(res);
        out_c++;
        if (out_c >= w) begin
            out_c = 0;
            out_r++;
            if (out_r >= h) begin
                out_r = 0;
                frame_open = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_res;
        if (!rst_n) begin
            width_reg  = 640;
            height_reg = 480;
            win_reg    = 3;
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
            frame_full = 0;
            frame_open = 0;
            fail_count = 0;
            medians_due.delete();
        end else begin
            // result check against the oldest expectation
            if (out_valid && out_ready) begin
                if (medians_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result median=%0d last=%0b",
                                 out_data.median_out, out_data.frame_last);
                end else begin
                    exp_res = medians_due.pop_front();
                    if (out_data.median_out !== exp_res.median_out ||
                        out_data.frame_last !== exp_res.frame_last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp median=%0d last=%0b, got median=%0d last=%0b",
                                     exp_res.median_out, exp_res.frame_last,
                                     out_data.median_out, out_data.frame_last);
                    end
                end
            end
            // register write restarts the frame; unknown index ignored
            if (cfg_wr_en && cfg_index <= REG_WINDOW) begin
                case (cfg_index)
                    REG_WIDTH:  width_reg  = cfg_data[WIDTH_REG_W-1:0];
                    REG_HEIGHT: height_reg = cfg_data[HEIGHT_REG_W-1:0];
                    default:    win_reg    = cfg_data[WIN_REG_W-1:0];
                endcase
                in_r = 0; in_c = 0; out_r = 0; out_c = 0;
                frame_full = 0;
                frame_open = 0;
                medians_due.delete();
            end
            if (in_valid && in_ready)
                predict_request(in_data);
        end
        pending = medians_due.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for median_filter_2d: clock, reset, request stimulus and verdict.
// Depends on mf2d_pkg, median_filter_2d and median_checker.
module tb_top;
    import mf2d_pkg::*;

    localparam int LIMIT = 5000000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    bit                    frame_open;
    int unsigned           cyc = 0;
    int unsigned           pushed = 0;
    bit                    big_done = 0;

    median_filter_2d dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    median_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .frame_open(frame_open)
    );

    always #4 clk = ~clk;

    // cycle count and watchdog
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // no idling on either side in this window
    function automatic bit busy_stretch();
        return cyc >= 30000 && cyc < 90000;
    endfunction

    // receiver: random stalls, plus one long hold-off to back up the block
    initial
    begin
        int unsigned held;
        held = 0;
        forever begin
            @(negedge clk);
            if (cyc >= 150000 && held < 3000) begin
                held++;
                out_ready <= 1'b0;
            end else begin
                out_ready <= busy_stretch() || ($urandom_range(99) >= 32);
            end
        end
    end

    // all request tasks start and end at a falling edge
    task automatic issue(input logic cmd, input logic [PIX_W-1:0] pix);
        while (!busy_stretch() && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{command: cmd, pixel_in: pix};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (cmd == CMD_PUSH) pushed++;
    endtask

    // stop offering, let all results come back, then wait out the spare cycles asked for
    task automatic settle(input int unsigned spare);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (spare) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic set_format(input int unsigned w, input int unsigned h, input int unsigned win);
        cfg_write(REG_WIDTH, CFG_DATA_W'(w) | (CFG_DATA_W'($urandom_range(3)) << WIDTH_REG_W));
        cfg_write(REG_HEIGHT, CFG_DATA_W'(h));
        cfg_write(REG_WINDOW, CFG_DATA_W'(win) | (CFG_DATA_W'($urandom_range(1023)) << WIN_REG_W));
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // push npix pixels with some drain noise; drain the frame out if flush is set
    task automatic run_pixels(input int unsigned npix, input int unsigned drain_pct,
                              input bit flush);
        for (int unsigned i = 0; i < npix; i++) begin
            if ($urandom_range(99) < drain_pct)
                issue(CMD_DRAIN, PIX_W'($urandom_range(255)));
            issue(CMD_PUSH, PIX_W'($urandom_range(255)));
        end
        if (flush) begin
            while (frame_open) issue(CMD_DRAIN, PIX_W'($urandom_range(255)));
            issue(CMD_DRAIN, PIX_W'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned win,
                             input int unsigned npix, input int unsigned drain_pct,
                             input bit flush);
        set_format(w, h, win);
        run_pixels(npix, drain_pct, flush);
        settle(16);
    endtask

    initial
    begin
        int unsigned w, h, win, frames;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset format: drain with nothing ready, then extreme pixel values
        issue(CMD_DRAIN, 8'hFF);
        issue(CMD_PUSH, 8'h00);
        issue(CMD_PUSH, 8'hFF);
        issue(CMD_PUSH, 8'hAA);
        issue(CMD_PUSH, 8'h55);
        settle(16);
        // unknown register index is ignored
        cfg_write(2'd3, '1);
        cfg_wr_en <= 1'b0;
        @(negedge clk);

        // zero width, height and window: 1x1 frames back to back
        run_phase(0, 0, 0, 2, 0, 1);
        // even window taken as next lower odd
        run_phase(3, 3, 2, 9, 0, 1);
        // window larger than the frame, drains mixed in
        run_phase(4, 3, 7, 12, 30, 1);
        // oversize height, partial frame only
        run_phase(2, 8191, 5, 10, 0, 0);
        // second frame pushed straight after the first: old outputs dropped
        run_phase(3, 2, 3, 12, 0, 1);

        // random formats
        while (pushed < 1800) begin
            if (!big_done && pushed >= 600) begin
                // widest row, clipped to the maximum, single-row frame
                big_done = 1;
                run_phase(2047, 1, 7, MAX_WIDTH, 2, 1);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 10);
                win = $urandom_range(0, 7);
                frames = $urandom_range(1, 2);
                if ($urandom_range(5) == 0)
                    run_phase(w, h, win, $urandom_range(1, w * h), 8, 0);
                else
                    run_phase(w, h, win, frames * w * h, 8, 1);
            end
        end

        settle(500);
        if (fail_count == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
